/* hdl/bdq_pkg.sv */
// Shared types, codes and constants of the bounded deque with sorted insert.
`default_nettype none

package bdq_pkg;

    // Default sizes handed to the top level
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Cell outputs merged per group in the first level of the readout tree
    localparam int GROUP_SIZE = 16;

    // Field widths of the stream items
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 112;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_SORTED     = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_READ       = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_APPLY,
        S_GATHER,
        S_REPORT
    } state_t;

    // How each cell sets its mark before an insert
    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_ALL,
        MARK_GREATER
    } mark_t;

    // What the row of cells does in the apply cycle
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_POP_FRONT
    } act_t;

    typedef struct packed {
        logic  mark_en;
        mark_t mark;
        logic  apply_en;
        act_t  act;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* hdl/bdq_cell.sv */
// One storage cell of the deque row: holds one entry and its insert mark.
`default_nettype none

module bdq_cell #(
    parameter int CAPACITY   = bdq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int PW = $clog2(CAPACITY)
) (
    input  wire logic                         clk,
    input  wire bdq_pkg::cell_ctl_t           ctl,
    input  wire logic signed [DATA_WIDTH-1:0] word,
    input  wire logic signed [DATA_WIDTH-1:0] left_entry,
    input  wire logic signed [DATA_WIDTH-1:0] right_entry,
    input  wire logic [CW-1:0]                count,
    input  wire logic [PW-1:0]                rd_pos,
    input  wire logic [PW-1:0]                back_pos,
    input  wire logic                         after_self,
    input  wire logic                         after_prev,
    output logic signed [DATA_WIDTH-1:0]      entry,
    output logic                              gt,
    output logic [DATA_WIDTH-1:0]             rd_part,
    output logic [DATA_WIDTH-1:0]             back_part
);

    logic signed [DATA_WIDTH-1:0] entry_reg, entry_next;
    logic                         gt_reg, gt_next;
    logic                         occupied;
    logic                         reach;

    // This cell holds an entry, or is the first free place
    assign occupied = count > CW'(INDEX);
    assign reach    = count >= CW'(INDEX);

    // Set the mark: an occupied cell that the new word must stay behind
    always_comb
    begin
        gt_next = gt_reg;
        if (ctl.mark_en)
        begin
            unique case (ctl.mark)
                bdq_pkg::MARK_NONE:    gt_next = 1'b0;
                bdq_pkg::MARK_ALL:     gt_next = occupied;
                bdq_pkg::MARK_GREATER: gt_next = occupied && (entry_reg > word);
                default:               gt_next = 1'b0;
            endcase
        end
    end

    // Hold, load the new word, or take a neighbour's entry
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.apply_en)
        begin
            unique case (ctl.act)
                bdq_pkg::ACT_INSERT:
                begin
                    priority if (after_self)
                        entry_next = entry_reg;
                    else if (after_prev)
                        entry_next = word;
                    else if (reach)
                        entry_next = left_entry;
                    else
                        entry_next = entry_reg;
                end
                bdq_pkg::ACT_POP_FRONT: entry_next = right_entry;
                default:                entry_next = entry_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        gt_reg    <= gt_next;
    end

    // Offer the entry to the readout trees when addressed
    assign entry     = entry_reg;
    assign gt        = gt_reg;
    assign rd_part   = (rd_pos == PW'(INDEX)) ? entry_reg : '0;
    assign back_part = (back_pos == PW'(INDEX)) ? entry_reg : '0;

endmodule

`default_nettype wire

/* hdl/bdq_scan.sv */
// Suffix OR over the cell marks: flags every cell with a marked cell at or behind it.
`default_nettype none

module bdq_scan #(
    parameter int N = bdq_pkg::CAPACITY_DEF,
    localparam int L = (N > 1) ? $clog2(N) : 1
) (
    input  wire logic [N-1:0] flags,
    output logic [N-1:0]      suffix
);

    logic [N-1:0] lvl [0:L];

    assign lvl[0] = flags;

    // Log-depth prefix network, each level doubling the span
    for (genvar k = 0; k < L; k++)
    begin : g_level
        for (genvar i = 0; i < N; i++)
        begin : g_bit
            if (i + (1 << k) < N)
            begin : g_join
                assign lvl[k+1][i] = lvl[k][i] | lvl[k][i + (1 << k)];
            end
            else
            begin : g_pass
                assign lvl[k+1][i] = lvl[k][i];
            end
        end
    end

    assign suffix = lvl[L];

endmodule

`default_nettype wire

/* hdl/bdq_merge.sv */
// Two-level OR tree that collects the one addressed cell entry, first level registered.
`default_nettype none

module bdq_merge #(
    parameter int N     = bdq_pkg::CAPACITY_DEF,
    parameter int W     = bdq_pkg::DATA_WIDTH_DEF,
    parameter int GROUP = bdq_pkg::GROUP_SIZE,
    localparam int G = (N + GROUP - 1) / GROUP
) (
    input  wire logic                  clk,
    input  wire logic [N-1:0][W-1:0]   parts,
    output logic [W-1:0]               merged
);

    logic [G-1:0][W-1:0] group_reg, group_next;

    // Merge each group of cells
    always_comb
    begin
        group_next = '0;
        for (int g = 0; g < G; g++)
        begin
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < N)
                    group_next[g] = group_next[g] | parts[g * GROUP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    // Merge the group results
    always_comb
    begin
        merged = '0;
        for (int g = 0; g < G; g++)
            merged = merged | group_reg[g];
    end

endmodule

`default_nettype wire

/* hdl/bounded_deque_with_sorted_insert.sv */
// Top level of the bounded deque with sorted insert: row of cells, control and output stage.
//
// One command per input transaction on the s_ stream, one result per command on the m_
// stream. Commands: push front, push back, sorted insert (placed right behind the nearest
// greater entry scanning from the back), pop front, pop back, read by index from the back.
// Each result carries the status, the read word and the front, back, count and empty flag
// after the command.
// After acceptance a command steps through mark (every cell compares against the new word
// in parallel), apply (every cell shifts, loads or holds at once), gather (first level of
// the readout tree) and report (result loaded into the output register).
// The result becomes valid in the same cycle as s_tready returns, so the block takes no new
// command until the previous one has loaded its result into the output register.
// While the output register still holds an untaken result, the next command is accepted and
// processed, and waits in the report step until m_tready frees the register.
// Reset empties the deque (count zero) and clears the output valid flag; entries are not
// cleared, since the count keeps every read within written entries.
`default_nettype none

module bounded_deque_with_sorted_insert #(
    parameter int CAPACITY   = bdq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // command[2:0], value[34:3], index[40:35], zero fill
    input  wire logic [bdq_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[1:0], read_value[33:2], front_value[65:34], back_value[97:66],
    // entry_count[104:98], is_empty[105], zero fill
    output logic [bdq_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > bdq_pkg::INDEX_W) ? CW : bdq_pkg::INDEX_W;

    bdq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    bdq_pkg::status_t status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic [bdq_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    bdq_pkg::cmd_t                cmd_reg;
    logic signed [DATA_WIDTH-1:0] word_reg;
    logic [bdq_pkg::INDEX_W-1:0]  idx_reg;

    logic                         s_accept;
    logic signed [bdq_pkg::VALUE_W-1:0] in_value;

    bdq_pkg::status_t   status_calc;
    bdq_pkg::mark_t     mark_calc;
    bdq_pkg::act_t      act_calc;
    logic               inc_calc;
    logic               dec_calc;
    logic               full;
    logic               empty;
    logic               idx_out;
    bdq_pkg::cell_ctl_t cell_ctl;

    logic [PW-1:0] rd_pos;
    logic [PW-1:0] back_pos;

    logic signed [DATA_WIDTH-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0]          cell_gt;
    logic [CAPACITY-1:0]          cell_after;
    logic [CAPACITY-1:0][DATA_WIDTH-1:0] rd_parts;
    logic [CAPACITY-1:0][DATA_WIDTH-1:0] back_parts;
    logic [DATA_WIDTH-1:0]        rd_merged;
    logic [DATA_WIDTH-1:0]        back_merged;
    logic signed [DATA_WIDTH-1:0] rd_word;
    logic signed [DATA_WIDTH-1:0] back_word;
    logic signed [bdq_pkg::VALUE_W-1:0] rd_out;
    logic signed [bdq_pkg::VALUE_W-1:0] front_out;
    logic signed [bdq_pkg::VALUE_W-1:0] back_out;

    // Input handshake
    assign s_tready = (state_reg == bdq_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_value = s_tdata[34:3];

    // Capture the command on acceptance
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg  <= bdq_pkg::cmd_t'(s_tdata[2:0]);
            word_reg <= DATA_WIDTH'(in_value);
            idx_reg  <= s_tdata[40:35];
        end
    end

    // Decode the command against the current count
    assign full    = count_reg >= CW'(CAPACITY);
    assign empty   = (count_reg == '0);
    assign idx_out = CMPW'(idx_reg) >= CMPW'(count_reg);

    always_comb
    begin
        status_calc = bdq_pkg::STATUS_OK;
        mark_calc   = bdq_pkg::MARK_NONE;
        act_calc    = bdq_pkg::ACT_NONE;
        inc_calc    = 1'b0;
        dec_calc    = 1'b0;
        unique case (cmd_reg)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK, bdq_pkg::CMD_SORTED:
            begin
                if (full)
                    status_calc = bdq_pkg::STATUS_FULL;
                else
                begin
                    act_calc = bdq_pkg::ACT_INSERT;
                    inc_calc = 1'b1;
                end
                if (cmd_reg == bdq_pkg::CMD_PUSH_BACK)
                    mark_calc = bdq_pkg::MARK_ALL;
                else if (cmd_reg == bdq_pkg::CMD_SORTED)
                    mark_calc = bdq_pkg::MARK_GREATER;
            end
            bdq_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                    status_calc = bdq_pkg::STATUS_EMPTY;
                else
                begin
                    act_calc = bdq_pkg::ACT_POP_FRONT;
                    dec_calc = 1'b1;
                end
            end
            bdq_pkg::CMD_POP_BACK:
            begin
                if (empty)
                    status_calc = bdq_pkg::STATUS_EMPTY;
                else
                    dec_calc = 1'b1;
            end
            bdq_pkg::CMD_READ:
            begin
                if (idx_out)
                    status_calc = bdq_pkg::STATUS_RANGE;
            end
            default:
            begin
                status_calc = bdq_pkg::STATUS_OK;
            end
        endcase
    end

    assign cell_ctl = '{
        mark_en:  (state_reg == bdq_pkg::S_MARK),
        mark:     mark_calc,
        apply_en: (state_reg == bdq_pkg::S_APPLY),
        act:      act_calc
    };

    // Readout addresses, valid in the gather cycle
    assign rd_pos   = PW'(CMPW'(count_reg) - CMPW'(1) - CMPW'(idx_reg));
    assign back_pos = PW'(count_reg - CW'(1));

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_entry;
        logic signed [DATA_WIDTH-1:0] right_entry;
        logic                         after_prev;

        if (i == 0)
        begin : g_first
            assign left_entry = word_reg;
            assign after_prev = 1'b1;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign after_prev = cell_after[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        bdq_cell #(
            .CAPACITY   (CAPACITY),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .word        (word_reg),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .count       (count_reg),
            .rd_pos      (rd_pos),
            .back_pos    (back_pos),
            .after_self  (cell_after[i]),
            .after_prev  (after_prev),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i]),
            .rd_part     (rd_parts[i]),
            .back_part   (back_parts[i])
        );
    end

    bdq_scan #(
        .N (CAPACITY)
    ) u_scan (
        .flags  (cell_gt),
        .suffix (cell_after)
    );

    bdq_merge #(
        .N     (CAPACITY),
        .W     (DATA_WIDTH),
        .GROUP (bdq_pkg::GROUP_SIZE)
    ) u_merge_rd (
        .clk    (clk),
        .parts  (rd_parts),
        .merged (rd_merged)
    );

    bdq_merge #(
        .N     (CAPACITY),
        .W     (DATA_WIDTH),
        .GROUP (bdq_pkg::GROUP_SIZE)
    ) u_merge_back (
        .clk    (clk),
        .parts  (back_parts),
        .merged (back_merged)
    );

    // Widen the stored words to the 32-bit result fields
    assign rd_word   = rd_merged;
    assign back_word = back_merged;
    assign rd_out    = ((cmd_reg == bdq_pkg::CMD_READ) && (status_reg == bdq_pkg::STATUS_OK))
                       ? bdq_pkg::VALUE_W'(rd_word) : '0;
    assign front_out = empty ? '0 : bdq_pkg::VALUE_W'(cell_entry[0]);
    assign back_out  = empty ? '0 : bdq_pkg::VALUE_W'(back_word);

    // Sequence the command and load the result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                if (s_accept)
                    state_next = bdq_pkg::S_MARK;
            end
            bdq_pkg::S_MARK:
            begin
                state_next = bdq_pkg::S_APPLY;
            end
            bdq_pkg::S_APPLY:
            begin
                status_next = status_calc;
                if (inc_calc)
                    count_next = count_reg + CW'(1);
                else if (dec_calc)
                    count_next = count_reg - CW'(1);
                state_next = bdq_pkg::S_GATHER;
            end
            bdq_pkg::S_GATHER:
            begin
                state_next = bdq_pkg::S_REPORT;
            end
            bdq_pkg::S_REPORT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, empty, bdq_pkg::COUNT_W'(count_reg),
                                      back_out, front_out, rd_out, status_reg};
                    state_next     = bdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/bdq_checker.sv */
// Port-level checks of the bounded deque with sorted insert, bound to the top level.
`default_nettype none

module bdq_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [bdq_pkg::M_DATA_W-1:0] m_tdata
);

    // One command in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while another is in flight");

    // The empty flag agrees with the count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[105] == (m_tdata[104:98] == 7'd0)))
        else $error("empty flag disagrees with entry count");

    // An empty deque reports zero front and back
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[105]) |-> ((m_tdata[65:34] == 32'd0) && (m_tdata[97:66] == 32'd0)))
        else $error("empty deque reports a front or back value");

    // A stalled result holds
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind bounded_deque_with_sorted_insert bdq_checker u_bdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the bounded deque with sorted insert on its stream ports.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = bdq_pkg::CAPACITY_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int RANDOM_ITEMS_PER_PHASE = 190;

    // Command codes the block decodes as no operation
    localparam logic [bdq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [bdq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // One result transaction, fields in the order of m_tdata from the top down
    typedef struct packed {
        logic                         is_empty;
        logic [bdq_pkg::COUNT_W-1:0]  entry_count;
        logic [31:0]                  back_value;
        logic [31:0]                  front_value;
        logic [31:0]                  read_value;
        logic [bdq_pkg::STATUS_W-1:0] status;
    } deque_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [bdq_pkg::S_DATA_W-1:0] s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [bdq_pkg::M_DATA_W-1:0] m_tdata;

    // Mirror of the deque contents, front at index 0
    logic [31:0]   deque_words [DEPTH];
    int            deque_len;
    int            deepest_fill;
    deque_result_t pending_results [$];

    int failures;
    int commands_sent;
    int results_seen;
    int status_tally [4];
    int send_gap_pct;
    int recv_stall_pct;

    bounded_deque_with_sorted_insert dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Apply one command to the mirror and return the result it must produce
    function automatic deque_result_t apply_to_mirror(input logic [bdq_pkg::CMD_W-1:0] cmd,
                                                      input logic [31:0] value,
                                                      input logic [5:0] index);
        deque_result_t r;
        int pos;
        int k;
        r = '0;
        case (cmd)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK, bdq_pkg::CMD_SORTED:
            begin
                if (deque_len >= DEPTH)
                    r.status = bdq_pkg::STATUS_FULL;
                else
                begin
                    if (cmd == bdq_pkg::CMD_PUSH_FRONT)
                        pos = 0;
                    else
                        pos = deque_len;
                    // Walk from the back past every entry not greater than the new word
                    if (cmd == bdq_pkg::CMD_SORTED)
                        while (pos > 0 && !($signed(value) < $signed(deque_words[pos-1])))
                            pos--;
                    for (k = deque_len; k > pos; k--)
                        deque_words[k] = deque_words[k-1];
                    deque_words[pos] = value;
                    deque_len++;
                end
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK:
            begin
                if (deque_len == 0)
                    r.status = bdq_pkg::STATUS_EMPTY;
                else
                begin
                    if (cmd == bdq_pkg::CMD_POP_FRONT)
                        for (k = 0; k + 1 < deque_len; k++)
                            deque_words[k] = deque_words[k+1];
                    deque_len--;
                end
            end
            bdq_pkg::CMD_READ:
            begin
                if (int'(index) >= deque_len)
                    r.status = bdq_pkg::STATUS_RANGE;
                else
                    r.read_value = deque_words[deque_len - 1 - int'(index)];
            end
            default:
            begin
            end
        endcase
        if (deque_len > 0)
        begin
            r.front_value = deque_words[0];
            r.back_value  = deque_words[deque_len-1];
        end
        r.entry_count = bdq_pkg::COUNT_W'(deque_len);
        r.is_empty    = (deque_len == 0);
        if (deque_len > deepest_fill)
            deepest_fill = deque_len;
        status_tally[r.status]++;
        return r;
    endfunction

    // Send one command transaction and record what it must return
    task automatic send_command(input logic [bdq_pkg::CMD_W-1:0] cmd, input logic [31:0] value,
                                input logic [5:0] index);
        // Idle the sender cycle by cycle at the current rate
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {7'd0, index, value, cmd};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_to_mirror(cmd, value, index));
        commands_sent++;
    endtask

    // Word for push and insert: many small values to force equal keys, some extremes
    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return 32'($signed($urandom_range(8)) - 4);
        else if (roll < 40)
            case ($urandom_range(3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        return $urandom;
    endfunction

    // Read position: mostly inside the current fill, sometimes anywhere
    function automatic logic [5:0] pick_index();
        if (deque_len > 0 && $urandom_range(99) < 70)
            return 6'($urandom_range(deque_len - 1));
        return 6'($urandom_range(63));
    endfunction

    // Pick one of the three storing commands
    function automatic logic [bdq_pkg::CMD_W-1:0] pick_store_cmd();
        case ($urandom_range(2))
            0: return bdq_pkg::CMD_PUSH_FRONT;
            1: return bdq_pkg::CMD_PUSH_BACK;
            default: return bdq_pkg::CMD_SORTED;
        endcase
    endfunction

    // Pop from either end until the deque is empty
    task automatic drain_deque();
        while (deque_len > 0)
            send_command($urandom_range(1) ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK,
                         $urandom, 6'($urandom));
    endtask

    // Pops and reads with nothing stored
    task automatic test_empty_errors();
        send_command(bdq_pkg::CMD_POP_FRONT, 32'h0, 6'd0);
        send_command(bdq_pkg::CMD_POP_BACK, 32'hffff_ffff, 6'd63);
        send_command(bdq_pkg::CMD_READ, 32'h0, 6'd0);
        send_command(bdq_pkg::CMD_READ, 32'h0, 6'd63);
    endtask

    // Pushes at both ends with extreme words, then reads in and out of range
    task automatic test_push_extremes();
        send_command(bdq_pkg::CMD_PUSH_BACK, 32'h7fff_ffff, 6'd0);
        send_command(bdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 6'd63);
        send_command(bdq_pkg::CMD_PUSH_BACK, 32'h0000_0000, 6'd0);
        send_command(bdq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff, 6'd0);
        send_command(bdq_pkg::CMD_READ, 32'h0, 6'd0);
        send_command(bdq_pkg::CMD_READ, 32'h0, 6'd3);
        send_command(bdq_pkg::CMD_READ, 32'h0, 6'd4);
        send_command(bdq_pkg::CMD_READ, 32'hffff_ffff, 6'd63);
    endtask

    // Sorted inserts with equal keys and sign extremes into an empty deque
    task automatic test_sorted_insert();
        drain_deque();
        send_command(bdq_pkg::CMD_SORTED, 32'd5, 6'd0);
        send_command(bdq_pkg::CMD_SORTED, 32'd5, 6'd0);
        send_command(bdq_pkg::CMD_SORTED, 32'd9, 6'd0);
        send_command(bdq_pkg::CMD_SORTED, 32'hffff_fffd, 6'd0);
        send_command(bdq_pkg::CMD_SORTED, 32'h8000_0000, 6'd0);
        send_command(bdq_pkg::CMD_SORTED, 32'h7fff_ffff, 6'd0);
        send_command(bdq_pkg::CMD_READ, 32'h0, 6'd2);
    endtask

    // Codes outside the command set must leave the contents alone
    task automatic test_unused_codes();
        send_command(CMD_SPARE_LO, 32'h1234_5678, 6'd0);
        send_command(CMD_SPARE_HI, 32'hffff_ffff, 6'd63);
    endtask

    // Random traffic: mostly sorted builds and fills, the rest raw noise
    task automatic test_random_traffic(input int item_budget);
        int stop_at;
        int roll;
        int steps;
        int n;
        stop_at = commands_sent + item_budget;
        while (commands_sent < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                // Descending list built by sorted inserts, read back, then trimmed
                drain_deque();
                steps = $urandom_range(4, 40);
                for (n = 0; n < steps; n++)
                    if ($urandom_range(3) == 0)
                        send_command(bdq_pkg::CMD_READ, $urandom, pick_index());
                    else
                        send_command(bdq_pkg::CMD_SORTED, pick_word(), 6'($urandom));
                steps = $urandom_range(0, 6);
                for (n = 0; n < steps; n++)
                    send_command($urandom_range(1) ? bdq_pkg::CMD_POP_FRONT
                                                   : bdq_pkg::CMD_POP_BACK,
                                 $urandom, 6'($urandom));
            end
            else if (roll < 65)
            begin
                // Fill to capacity, overflow it, and read at the deepest positions
                while (deque_len < DEPTH)
                    send_command(pick_store_cmd(), pick_word(), 6'($urandom));
                steps = $urandom_range(1, 3);
                for (n = 0; n < steps; n++)
                    send_command(pick_store_cmd(), pick_word(), 6'($urandom));
                send_command(bdq_pkg::CMD_READ, $urandom, 6'd63);
                send_command(bdq_pkg::CMD_READ, $urandom, 6'd0);
                send_command(bdq_pkg::CMD_READ, $urandom, pick_index());
            end
            else
            begin
                // Any code, any word, any index
                steps = $urandom_range(10, 30);
                for (n = 0; n < steps; n++)
                    send_command(bdq_pkg::CMD_W'($urandom_range(7)), pick_word(),
                                 6'($urandom));
            end
        end
    endtask

    // Compare one field and report a mismatch
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: result %0d %s mismatch: expected %h actual %h",
                     $time, results_seen, field, want, got);
            failures++;
        end
    endtask

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        deque_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[105:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: expected none actual %h",
                         $time, m_tdata);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("read_value", want.read_value, got.read_value);
                check_field("front_value", want.front_value, got.front_value);
                check_field("back_value", want.back_value, got.back_value);
                check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            end
            results_seen++;
        end
    end

    // Receiver readiness, stalling at the current rate
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort when no transaction moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("tb_top NOT OK");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        deque_len      = 0;
        deepest_fill   = 0;
        failures       = 0;
        commands_sent  = 0;
        results_seen   = 0;
        status_tally   = '{0, 0, 0, 0};
        send_gap_pct   = 7;
        recv_stall_pct = 77;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver mostly stalling
        test_empty_errors();
        test_push_extremes();
        test_sorted_insert();
        test_unused_codes();
        test_random_traffic(RANDOM_ITEMS_PER_PHASE);

        // Sender mostly idle, receiver mostly ready
        send_gap_pct   = 77;
        recv_stall_pct = 7;
        test_random_traffic(RANDOM_ITEMS_PER_PHASE);

        // Both sides at full rate
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_traffic(RANDOM_ITEMS_PER_PHASE);

        // Let every result come home, then watch for strays
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d commands, %0d results: %0d ok, %0d empty, %0d full, %0d range.",
                 commands_sent, results_seen, status_tally[bdq_pkg::STATUS_OK],
                 status_tally[bdq_pkg::STATUS_EMPTY], status_tally[bdq_pkg::STATUS_FULL],
                 status_tally[bdq_pkg::STATUS_RANGE]);
        $display("Deepest fill %0d of %0d entries, %0d mismatches.",
                 deepest_fill, DEPTH, failures);
        if (failures == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
